/* rtl/iiel_pkg.sv */
// Package for the indexed insert/erase list.
// Holds request and status codes, the cell operation struct and the read-out group size.
// Depends on nothing; used by iiel_cell and indexed_insert_erase_list.
package iiel_pkg;

  typedef enum logic [1:0] {
    REQ_INSERT = 2'd0,
    REQ_ERASE  = 2'd1,
    REQ_READ   = 2'd2,
    REQ_NONE   = 2'd3
  } iiel_req_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_RANGE = 2'd1,
    ST_FULL  = 2'd2,
    ST_SPARE = 2'd3
  } iiel_status_e;

  typedef struct packed {
    logic ins;
    logic ers;
    logic rd;
  } iiel_op_t;

  localparam int unsigned GROUP_SIZE = 32;

endpackage

/* rtl/indexed_insert_erase_list.sv */
// Indexed insert/erase list: a row of DEPTH cells that shift together on insert and erase.
// A result passes the registered read-out tree between the cells and the output, then the output
// register; a new request is taken only once that result is loaded, which waits on a stalled output.
// Reset clears the entry count and the handshake state; the entries themselves are not cleared.
// Depends on iiel_pkg and iiel_cell.
module indexed_insert_erase_list #(
  parameter int unsigned DEPTH     = 64,
  parameter int unsigned WORD_BITS = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // Fields from bit 0: position[6:0], value_in[38:7], zero fill.
  input  logic [39:0] s_axis_tdata,
  // Fields from bit 0: req_type[1:0].
  input  logic [1:0]  s_axis_tuser,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // Fields from bit 0: value_out[31:0], count_out[38:32], zero fill.
  output logic [39:0] m_axis_tdata,
  // Fields from bit 0: status[1:0].
  output logic [1:0]  m_axis_tuser
);
  import iiel_pkg::*;

  localparam int unsigned IW     = $clog2(DEPTH);
  localparam int unsigned CW     = $clog2(DEPTH + 1);
  localparam int unsigned PW     = (CW > 7) ? CW : 7;
  localparam int unsigned GROUPS = (DEPTH + GROUP_SIZE - 1) / GROUP_SIZE;

  typedef enum logic {
    S_IDLE,
    S_WAIT
  } state_e;

  state_e               state_q;
  logic [CW-1:0]        count_q;
  iiel_status_e         pend_status_q;
  logic                 m_valid_q;
  logic [1:0]           m_user_q;
  logic [39:0]          m_data_q;
  logic [WORD_BITS-1:0] grp_q [GROUPS];
  logic [WORD_BITS-1:0] grp_d [GROUPS];
  logic [WORD_BITS-1:0] rd_all;

  logic                 accept;
  logic [PW-1:0]        pos_ext, cnt_ext;
  logic                 is_full;
  iiel_req_e            req;
  iiel_op_t             op;
  iiel_status_e         status_d;
  logic [CW-1:0]        count_d;
  logic [WORD_BITS-1:0] word;
  logic [IW-1:0]        pos_cell;

  logic [WORD_BITS-1:0] cell_data [DEPTH];
  logic [WORD_BITS-1:0] cell_rd   [DEPTH];

  assign s_axis_tready = state_q == S_IDLE;
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign req           = iiel_req_e'(s_axis_tuser);
  assign pos_ext       = PW'(s_axis_tdata[6:0]);
  assign cnt_ext       = PW'(count_q);
  assign is_full       = count_q == CW'(DEPTH);
  assign pos_cell      = pos_ext[IW-1:0];
  assign word          = WORD_BITS'(s_axis_tdata[38:7]);

  always_comb begin
    op       = '0;
    status_d = ST_RANGE;
    count_d  = count_q;
    unique case (req)
      REQ_INSERT: begin
        if (pos_ext > cnt_ext) begin
          status_d = ST_RANGE;
        end else if (is_full) begin
          status_d = ST_FULL;
        end else begin
          status_d = ST_OK;
          op.ins   = accept;
          count_d  = count_q + CW'(1);
        end
      end
      REQ_ERASE: begin
        if (pos_ext < cnt_ext) begin
          status_d = ST_OK;
          op.ers   = accept;
          count_d  = count_q - CW'(1);
        end
      end
      REQ_READ: begin
        if (pos_ext < cnt_ext) begin
          status_d = ST_OK;
          op.rd    = accept;
        end
      end
      default: begin
        status_d = ST_RANGE;
      end
    endcase
  end

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [WORD_BITS-1:0] left, right;
    if (i == 0) begin : g_first
      assign left = word;
    end else begin : g_mid
      assign left = cell_data[i-1];
    end
    if (i == DEPTH - 1) begin : g_last
      assign right = cell_data[i];
    end else begin : g_inner
      assign right = cell_data[i+1];
    end
    iiel_cell #(
      .WORD_BITS(WORD_BITS),
      .IW       (IW)
    ) u_cell (
      .clk_i  (clk_i),
      .op_i   (op),
      .idx_i  (IW'(i)),
      .pos_i  (pos_cell),
      .word_i (word),
      .left_i (left),
      .right_i(right),
      .data_o (cell_data[i]),
      .rd_o   (cell_rd[i])
    );
  end

  always_comb begin
    for (int g = 0; g < GROUPS; g++) begin
      grp_d[g] = '0;
      for (int k = 0; k < GROUP_SIZE; k++) begin
        if (g * GROUP_SIZE + k < DEPTH) begin
          grp_d[g] = grp_d[g] | cell_rd[g*GROUP_SIZE+k];
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      grp_q <= grp_d;
    end
  end

  always_comb begin
    rd_all = '0;
    for (int g = 0; g < GROUPS; g++) begin
      rd_all = rd_all | grp_q[g];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= S_IDLE;
      count_q       <= '0;
      pend_status_q <= ST_OK;
      m_valid_q     <= 1'b0;
      m_user_q      <= '0;
      m_data_q      <= '0;
    end else begin
      unique case (state_q)
        S_IDLE: begin
          if (m_valid_q && m_axis_tready) begin
            m_valid_q <= 1'b0;
          end
          if (accept) begin
            count_q       <= count_d;
            pend_status_q <= status_d;
            state_q       <= S_WAIT;
          end
        end
        S_WAIT: begin
          if (!m_valid_q || m_axis_tready) begin
            m_valid_q <= 1'b1;
            m_user_q  <= pend_status_q;
            m_data_q  <= {1'b0, 7'(count_q), 32'(rd_all)};
            state_q   <= S_IDLE;
          end
        end
        default: begin
          if (m_valid_q && m_axis_tready) begin
            m_valid_q <= 1'b0;
          end
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tuser  = m_user_q;
  assign m_axis_tdata  = m_data_q;

endmodule

/* rtl/iiel_cell.sv */
// One cell of the list: holds a single entry and trades it with its neighbors.
// Depends on iiel_pkg for the operation struct.
module iiel_cell #(
  parameter int unsigned WORD_BITS = 32,
  parameter int unsigned IW        = 6
) (
  input  logic                 clk_i,
  input  iiel_pkg::iiel_op_t   op_i,
  input  logic [IW-1:0]        idx_i,
  input  logic [IW-1:0]        pos_i,
  input  logic [WORD_BITS-1:0] word_i,
  input  logic [WORD_BITS-1:0] left_i,
  input  logic [WORD_BITS-1:0] right_i,
  output logic [WORD_BITS-1:0] data_o,
  output logic [WORD_BITS-1:0] rd_o
);
  import iiel_pkg::*;

  logic [WORD_BITS-1:0] data_q, data_d;
  logic                 above, at;

  assign above = idx_i > pos_i;
  assign at    = idx_i == pos_i;

  always_comb begin
    data_d = data_q;
    if (op_i.ins) begin
      if (above) begin
        data_d = left_i;
      end else if (at) begin
        data_d = word_i;
      end
    end else if (op_i.ers && (above || at)) begin
      data_d = right_i;
    end
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign data_o = data_q;
  assign rd_o   = (op_i.rd && at) ? data_q : '0;

endmodule

/* tb/sv/tb_top.sv */
`timescale 1ns / 100ps
// Self-checking testbench for indexed_insert_erase_list: directed and random requests
// with idle and stall phases, checked by a scoreboard that predicts every transaction.
// Depends on iiel_pkg and the indexed_insert_erase_list RTL.
module tb_top;
  import iiel_pkg::*;

  localparam int unsigned LIST_DEPTH  = 64;
  localparam int unsigned CYCLE_LIMIT = 200000;
  localparam int unsigned BLOCK_ITEMS = 105;

  typedef struct packed {
    iiel_status_e status;
    logic [31:0]  word;
    logic [6:0]   count;
  } list_result_t;

  class list_scoreboard;
    logic [31:0]  entries [LIST_DEPTH];
    int unsigned  count;
    int unsigned  errors;
    list_result_t pending_results [$];

    function int unsigned pending();
      return pending_results.size();
    endfunction

    function void note_request(iiel_req_e kind, logic [6:0] pos, logic [31:0] word);
      list_result_t res;
      res.status = ST_RANGE;
      res.word   = '0;
      case (kind)
        REQ_INSERT: begin
          if (pos > count) begin
            res.status = ST_RANGE;
          end else if (count >= LIST_DEPTH) begin
            res.status = ST_FULL;
          end else begin
            for (int i = count; i > pos; i--) entries[i] = entries[i - 1];
            entries[pos] = word;
            count++;
            res.status = ST_OK;
          end
        end
        REQ_ERASE: begin
          if (pos < count) begin
            for (int i = pos; i + 1 < count; i++) entries[i] = entries[i + 1];
            count--;
            res.status = ST_OK;
          end
        end
        REQ_READ: begin
          if (pos < count) begin
            res.word   = entries[pos];
            res.status = ST_OK;
          end
        end
        default: begin
          res.status = ST_RANGE;
        end
      endcase
      res.count = count[6:0];
      pending_results.push_back(res);
    endfunction

    function void check_result(iiel_status_e status, logic [31:0] word, logic [6:0] cnt);
      list_result_t want;
      if (pending_results.size() == 0) begin
        $error("result transaction with no request outstanding");
        errors++;
        return;
      end
      want = pending_results.pop_front();
      if (status !== want.status) begin
        $error("status: expected %0d, actual %0d", want.status, status);
        errors++;
      end
      if (word !== want.word) begin
        $error("value_out: expected 0x%08h, actual 0x%08h", want.word, word);
        errors++;
      end
      if (cnt !== want.count) begin
        $error("count_out: expected %0d, actual %0d", want.count, cnt);
        errors++;
      end
    endfunction
  endclass

  logic        clk_i;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [39:0] s_axis_tdata;
  logic [1:0]  s_axis_tuser;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [39:0] m_axis_tdata;
  logic [1:0]  m_axis_tuser;

  int unsigned    send_idle_pct;
  int unsigned    recv_stall_pct;
  int unsigned    cycle_count = 0;
  list_scoreboard board;

  indexed_insert_erase_list #(
    .DEPTH    (LIST_DEPTH),
    .WORD_BITS(32)
  ) dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser)
  );

  initial clk_i = 1'b0;
  always #5 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("indexed_insert_erase_list: mismatch");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    if (m_axis_tvalid && m_axis_tready) begin
      board.check_result(iiel_status_e'(m_axis_tuser), m_axis_tdata[31:0],
                         m_axis_tdata[38:32]);
    end
    m_axis_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
  end

  task automatic send_request(input iiel_req_e kind, input logic [6:0] pos,
                              input logic [31:0] word);
    while (send_idle_pct != 0 && $urandom_range(0, 99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {1'b0, word, pos};
    s_axis_tuser  <= kind;
    do @(posedge clk_i); while (!s_axis_tready);
    board.note_request(kind, pos, word);
  endtask

  task automatic wait_for_results();
    s_axis_tvalid <= 1'b0;
    while (board.pending() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic random_request(input bit filling);
    int unsigned pick;
    int unsigned cnt;
    iiel_req_e   kind;
    logic [6:0]  pos;
    pick = $urandom_range(0, 99);
    cnt  = board.count;
    if (pick < (filling ? 80 : 10)) begin
      kind = REQ_INSERT;
    end else if (pick < (filling ? 88 : 78)) begin
      kind = REQ_ERASE;
    end else if (pick < 97) begin
      kind = REQ_READ;
    end else begin
      kind = REQ_NONE;
    end
    if ($urandom_range(0, 99) < 15) begin
      pos = 7'($urandom_range(0, 127));
    end else if (kind == REQ_INSERT) begin
      pos = 7'($urandom_range(0, cnt));
    end else if (cnt == 0) begin
      pos = '0;
    end else begin
      pos = 7'($urandom_range(0, cnt - 1));
    end
    send_request(kind, pos, $urandom());
  endtask

  initial begin
    bit filling;
    board          = new();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    rst_ni        <= 1'b0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    s_axis_tuser  <= REQ_NONE;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    send_request(REQ_READ, 7'd0, 32'h0);
    send_request(REQ_ERASE, 7'd0, 32'h0);
    send_request(REQ_INSERT, 7'd1, 32'h1234_5678);
    send_request(REQ_INSERT, 7'd0, 32'h7FFF_FFFF);
    send_request(REQ_INSERT, 7'd1, 32'h8000_0000);
    send_request(REQ_INSERT, 7'd0, 32'hFFFF_FFFF);
    send_request(REQ_INSERT, 7'd1, 32'h0000_0000);
    for (int i = 0; i < 4; i++) send_request(REQ_READ, i[6:0], 32'hFFFF_FFFF);
    send_request(REQ_NONE, 7'd0, 32'hFFFF_FFFF);
    send_request(REQ_READ, 7'd4, 32'h0);
    send_request(REQ_ERASE, 7'd1, 32'h0);
    send_request(REQ_ERASE, 7'd2, 32'h0);
    send_request(REQ_READ, 7'd127, 32'h0);
    send_request(REQ_INSERT, 7'd127, 32'h5555_AAAA);
    send_request(REQ_ERASE, 7'd64, 32'h0);
    send_request(REQ_ERASE, 7'd0, 32'h0);
    send_request(REQ_ERASE, 7'd0, 32'h0);
    send_request(REQ_READ, 7'd0, 32'h0);
    wait_for_results();

    while (board.count < LIST_DEPTH) begin
      send_request(REQ_INSERT, 7'($urandom_range(0, board.count)), $urandom());
    end
    send_request(REQ_INSERT, 7'd0, $urandom());
    send_request(REQ_INSERT, 7'd64, $urandom());
    send_request(REQ_INSERT, 7'd65, $urandom());
    send_request(REQ_READ, 7'd63, 32'h0);
    wait_for_results();

    filling = 1'b0;
    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin
          send_idle_pct  = 0;
          recv_stall_pct = 0;
        end
        1: begin
          send_idle_pct  = 55;
          recv_stall_pct = 0;
        end
        2: begin
          send_idle_pct  = 0;
          recv_stall_pct = 55;
        end
        default: begin
          send_idle_pct  = 8;
          recv_stall_pct = 8;
        end
      endcase
      for (int blk = 0; blk < 3; blk++) begin
        for (int n = 0; n < BLOCK_ITEMS; n++) begin
          random_request(filling);
        end
        filling = !filling;
        if (blk == 1) wait_for_results();
      end
      wait_for_results();
    end

    wait_for_results();
    repeat (10) @(posedge clk_i);
    if (board.errors == 0 && board.pending() == 0) begin
      $display("indexed_insert_erase_list: match");
    end else begin
      $display("indexed_insert_erase_list: mismatch");
    end
    $finish;
  end
endmodule

/* indexed_insert_erase_list.f */
rtl/iiel_pkg.sv
rtl/iiel_cell.sv
rtl/indexed_insert_erase_list.sv
tb/sv/tb_top.sv
